FILE: hdl/assert_macros.svh
// Assertion helpers. A macro is used by naming a label, a clock, a reset and the expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/rbom_pkg.sv
package rbom_pkg;

    localparam int MAX_DEPTH = 256;
    localparam int ADDR_W    = $clog2(MAX_DEPTH);
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int SUM_W     = 40;
    localparam int CFG_W     = 9;
    localparam int STEP_W    = $clog2(SUM_W + 1);

    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef enum logic [0:0] {
        REG_ELEMENT_TYPE = 1'b0,
        REG_DEPTH_IN_USE = 1'b1
    } t_reg_idx;

    localparam logic [1:0] ET_S8  = 2'd0;
    localparam logic [1:0] ET_S16 = 2'd1;
    localparam logic [1:0] ET_S32 = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } t_state;

    function automatic logic [DATA_W-1:0] narrow(input logic [DATA_W-1:0] raw,
                                                  input logic [1:0] etype);
        logic [DATA_W-1:0] v;
        begin
            case (etype)
                ET_S16:  v = {{(DATA_W-16){raw[15]}}, raw[15:0]};
                ET_S32:  v = raw;
                default: v = {{(DATA_W-8){raw[7]}}, raw[7:0]};
            endcase
            return v;
        end
    endfunction

    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] slot,
                                                     input logic [CNT_W-1:0] depth);
        logic [CNT_W-1:0] n;
        begin
            n = CNT_W'(slot) + CNT_W'(1);
            if (n >= depth) begin
                n = '0;
            end
            return n[ADDR_W-1:0];
        end
    endfunction

endpackage

FILE: hdl/ring_buffer_overwrite_mean_top.sv
// Ring store of up to 256 signed samples with overwrite when full and a running mean.
// Samples sit in one 256 x 32 RAM with a registered read port, and one beat is handled at a time.
// A beat passes these steps from acceptance to result:
//   - the RAM read is issued at the accepting edge,
//   - the read state updates the pointers and the 40-bit running sum and writes the RAM back,
//   - the prep state prepares the divider,
//   - the divide state runs the bit-serial restoring division of the sum by the fill count,
//   - the output state loads the output register.
// The next beat is taken once the result is in the output register, even if it has not yet
// been collected, so a new beat is never taken before the last one is through. A result still
// waiting downstream holds the following beat in its load cycle. Writing depth_in_use empties the
// store; writing element_type leaves stored samples as they are.
`include "assert_macros.svh"

module ring_buffer_overwrite_mean_top import rbom_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [0:0]               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_func,
    input  logic signed [DATA_W-1:0] i_sample_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_popped_sample,
    output logic                     o_popped_valid,
    output logic [CNT_W-1:0]         o_fill_count,
    output logic signed [DATA_W-1:0] o_mean_value,
    output logic                     o_store_empty
);

    t_state r_state, n_state;

    logic [1:0]        r_elem_type;
    logic [CNT_W-1:0]  r_depth_act;
    logic [ADDR_W-1:0] r_wr_slot, n_wr_slot;
    logic [ADDR_W-1:0] r_rd_slot, n_rd_slot;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]  r_sum, n_sum;

    t_func             r_func;
    logic [DATA_W-1:0] r_sample;
    logic [DATA_W-1:0] r_pop_sample, n_pop_sample;
    logic              r_pop_valid, n_pop_valid;

    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic              r_neg, n_neg;
    logic [STEP_W-1:0] r_step, n_step;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_pop_sample;
    logic              r_out_pop_valid;
    logic [CNT_W-1:0]  r_out_count;
    logic [DATA_W-1:0] r_out_mean;
    logic              r_out_empty;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    logic              in_accept;
    logic              out_load;
    logic              depth_wr;

    logic [CNT_W:0]    rem_sh;
    logic [CNT_W+1:0]  rem_diff;
    logic [DATA_W-1:0] quo_lo;
    logic [SUM_W-1:0]  sum_add, sum_sub;
    logic [CNT_W-1:0]  depth_clamped;

    rbom_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wr_slot),
        .i_wdata (r_sample),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_READ;
            ST_READ: n_state = ST_PREP;
            ST_PREP: n_state = ST_DIV;
            ST_DIV:  if (r_step == STEP_W'(1)) n_state = ST_OUT;
            ST_OUT:  if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- control outputs ----
    always_comb begin
        o_in_stall = 1'b1;
        mem_we     = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_READ: mem_we = (r_func == FUNC_PUSH);
            ST_PREP: ;
            ST_DIV:  ;
            ST_OUT:  out_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign mem_raddr = (t_func'(i_func) == FUNC_POP) ? r_rd_slot : r_wr_slot;
    assign depth_wr  = i_cfg_we && (t_reg_idx'(i_cfg_index) == REG_DEPTH_IN_USE);

    always_comb begin
        if (i_cfg_data == '0) begin
            depth_clamped = CNT_W'(1);
        end else if (CNT_W'(i_cfg_data) > CNT_W'(MAX_DEPTH)) begin
            depth_clamped = CNT_W'(MAX_DEPTH);
        end else begin
            depth_clamped = CNT_W'(i_cfg_data);
        end
    end

    // ---- store update (read-modify-write) ----
    always_comb begin
        n_wr_slot    = r_wr_slot;
        n_rd_slot    = r_rd_slot;
        n_count      = r_count;
        n_pop_sample = r_pop_sample;
        n_pop_valid  = r_pop_valid;
        sum_add      = '0;
        sum_sub      = '0;
        if (r_state == ST_READ) begin
            n_pop_sample = '0;
            n_pop_valid  = 1'b0;
            case (r_func)
                FUNC_PUSH: begin
                    // full: the slot being overwritten is the oldest one
                    if (r_count >= r_depth_act) begin
                        sum_sub   = {{(SUM_W-DATA_W){mem_rdata[DATA_W-1]}}, mem_rdata};
                        n_rd_slot = next_slot(r_rd_slot, r_depth_act);
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    sum_add   = {{(SUM_W-DATA_W){r_sample[DATA_W-1]}}, r_sample};
                    n_wr_slot = next_slot(r_wr_slot, r_depth_act);
                end
                FUNC_POP: begin
                    if (r_count != '0) begin
                        n_pop_sample = mem_rdata;
                        n_pop_valid  = 1'b1;
                        sum_sub      = {{(SUM_W-DATA_W){mem_rdata[DATA_W-1]}}, mem_rdata};
                        n_count      = r_count - CNT_W'(1);
                        n_rd_slot    = next_slot(r_rd_slot, r_depth_act);
                    end
                end
                FUNC_CLEAR: begin
                    n_wr_slot = '0;
                    n_rd_slot = '0;
                    n_count   = '0;
                end
                default: ;
            endcase
        end
        if (r_state == ST_READ && r_func == FUNC_CLEAR) begin
            n_sum = '0;
        end else begin
            n_sum = r_sum + sum_add - sum_sub;
        end
        if (depth_wr) begin
            n_wr_slot = '0;
            n_rd_slot = '0;
            n_count   = '0;
            n_sum     = '0;
        end
    end

    // ---- serial divider: |sum| / count, one quotient bit a cycle ----
    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, r_count};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_neg  = r_neg;
        n_step = r_step;
        if (r_state == ST_PREP) begin
            n_neg  = r_sum[SUM_W-1];
            n_quo  = r_sum[SUM_W-1] ? (~r_sum + SUM_W'(1)) : r_sum;
            n_rem  = '0;
            n_step = STEP_W'(SUM_W);
        end else if (r_state == ST_DIV) begin
            if (!rem_diff[CNT_W+1]) begin
                n_rem = rem_diff[CNT_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[CNT_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], 1'b0};
            end
            n_step = r_step - STEP_W'(1);
        end
    end

    assign quo_lo = r_quo[DATA_W-1:0];

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_elem_type <= ET_S32;
            r_depth_act <= CNT_W'(MAX_DEPTH);
            r_wr_slot   <= '0;
            r_rd_slot   <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state   <= n_state;
            r_wr_slot <= n_wr_slot;
            r_rd_slot <= n_rd_slot;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_step    <= n_step;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_ELEMENT_TYPE: r_elem_type <= i_cfg_data[1:0];
                    REG_DEPTH_IN_USE: r_depth_act <= depth_clamped;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func   <= t_func'(i_func);
            r_sample <= narrow(i_sample_in, r_elem_type);
        end
        r_pop_sample <= n_pop_sample;
        r_pop_valid  <= n_pop_valid;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_neg        <= n_neg;
        if (out_load) begin
            r_out_pop_sample <= r_pop_sample;
            r_out_pop_valid  <= r_pop_valid;
            r_out_count      <= r_count;
            r_out_empty      <= (r_count == '0);
            if (r_count == '0) begin
                r_out_mean <= '0;
            end else begin
                r_out_mean <= r_neg ? (~quo_lo + DATA_W'(1)) : quo_lo;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_popped_sample = r_out_pop_sample;
    assign o_popped_valid  = r_out_pop_valid;
    assign o_fill_count    = r_out_count;
    assign o_mean_value    = r_out_mean;
    assign o_store_empty   = r_out_empty;

    // ---- assertions ----
    `ASSERT_IMPL(a_count_in_depth, i_clk, i_rst_n, 1'b1, r_count <= r_depth_act)
    `ASSERT_IMPL(a_empty_flag, i_clk, i_rst_n, o_out_valid, o_store_empty == (o_fill_count == '0))
    `ASSERT_IMPL(a_empty_mean_zero, i_clk, i_rst_n, o_out_valid && o_store_empty, o_mean_value == '0)
    `ASSERT_NEXT(a_accept_reads, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == ST_READ)

endmodule

FILE: hdl/rbom_ram.sv
module rbom_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
